// ===== rtl/ising_chain_metropolis_step_top_assert.svh =====
// Assertion macros used by the checker file of the spin chain block.
`ifndef ISING_CHAIN_METROPOLIS_STEP_TOP_ASSERT_SVH
`define ISING_CHAIN_METROPOLIS_STEP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ICMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ICMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/icms_pkg.sv =====
// Types, constants and register codes of the spin chain Metropolis block.
package icms_pkg;

  localparam int unsigned NumSpinsDefault = 64;

  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned DrawW    = 16;
  localparam int unsigned ThrW     = 17;
  localparam int unsigned RegW     = 2 * ThrW;
  localparam int unsigned NumRegs  = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  // Both halves of every threshold register reset to 1.0, which always accepts.
  localparam logic [RegW-1:0] RegReset = 34'h2_0001_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NSUM_M1 = 3'd0,
    REG_NSUM_MH = 3'd1,
    REG_NSUM_Z  = 3'd2,
    REG_NSUM_PH = 3'd3,
    REG_NSUM_P1 = 3'd4
  } icms_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_TRIAL = 1'b1
  } icms_op_e;

  typedef struct packed {
    logic take_item;
    logic rd_left;
    logic rd_right;
    logic cap_centre;
    logic cap_left;
    logic commit;
    logic clear_wr;
  } icms_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic clear_last;
  } icms_sts_t;

endpackage

// ===== rtl/icms_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module icms_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/icms_ctrl.sv =====
// Sequencer of the spin chain block: clearing pass, spin reads and commit.
module icms_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  icms_pkg::icms_sts_t   sts_i,
  output icms_pkg::icms_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_C,
    ST_RD_L,
    ST_RD_R,
    ST_EVAL
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d         = ST_RD_C;
        end
      end
      ST_RD_C: begin
        state_d = ST_RD_L;
      end
      ST_RD_L: begin
        cmd_o.rd_left    = 1'b1;
        cmd_o.cap_centre = 1'b1;
        state_d          = ST_RD_R;
      end
      ST_RD_R: begin
        cmd_o.rd_right = 1'b1;
        cmd_o.cap_left = 1'b1;
        state_d        = ST_EVAL;
      end
      ST_EVAL: begin
        // The right neighbor stays on the read port until the result can leave.
        cmd_o.rd_right = 1'b1;
        if (sts_i.slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ===== rtl/icms_dp.sv =====
// Datapath: spin RAM, threshold registers, acceptance test, count and result.
module icms_dp #(
  parameter int unsigned NumSpins = icms_pkg::NumSpinsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [icms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [icms_pkg::RegW-1:0]     cfg_data_i,
  input  logic                          in_op_i,
  input  logic [icms_pkg::IdxW-1:0]     in_idx_i,
  input  logic                          in_val_i,
  input  logic [icms_pkg::DrawW-1:0]    in_draw_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_accepted_o,
  output logic                          out_spin_o,
  output logic [icms_pkg::CntW-1:0]     out_count_o,
  input  icms_pkg::icms_cmd_t           cmd_i,
  output icms_pkg::icms_sts_t           sts_o
);

  localparam int unsigned AddrW   = (NumSpins > 1) ? $clog2(NumSpins) : 1;
  localparam logic [31:0] NumLim  = 32'(NumSpins);
  localparam logic [31:0] LastIdx = 32'(NumSpins - 1);

  logic [icms_pkg::RegW-1:0] regs_q [icms_pkg::NumRegs];

  icms_pkg::icms_op_e         op_q;
  logic                       val_q;
  logic [icms_pkg::DrawW-1:0] draw_q;
  logic                       range_q, first_q, last_q;
  logic [AddrW-1:0]           addr_q;
  logic                       centre_q, left_q;
  logic [AddrW-1:0]           clr_q;
  logic [icms_pkg::CntW-1:0]  count_q, count_d;

  logic                       out_valid_q;
  logic                       out_acc_q, out_spin_q;
  logic [icms_pkg::CntW-1:0]  out_count_q;

  logic [31:0]                idx_wide;
  logic [AddrW-1:0]           raddr, waddr;
  logic                       ram_we, wdata, ram_rdata;
  logic                       nb_left, nb_right;
  icms_pkg::icms_reg_e        sel;
  logic [icms_pkg::RegW-1:0]  thr_reg;
  logic [icms_pkg::ThrW-1:0]  thr;
  logic                       flip, new_spin, change;

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(icms_pkg::NumRegs); i++) begin
        regs_q[i] <= icms_pkg::RegReset;
      end
    end else if (cfg_we_i && (cfg_idx_i <= icms_pkg::CfgIdxW'(icms_pkg::REG_NSUM_P1))) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Request capture and the flags that describe its place in the chain.
  assign idx_wide = 32'(in_idx_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      op_q    <= icms_pkg::icms_op_e'(in_op_i);
      val_q   <= in_val_i;
      draw_q  <= in_draw_i;
      range_q <= (idx_wide < NumLim);
      first_q <= (in_idx_i == '0);
      last_q  <= (idx_wide == LastIdx);
      addr_q  <= AddrW'(idx_wide);
    end
    if (cmd_i.cap_centre) begin
      centre_q <= ram_rdata;
    end
    if (cmd_i.cap_left) begin
      left_q <= ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  assign raddr = cmd_i.rd_left  ? (addr_q - AddrW'(1)) :
                 cmd_i.rd_right ? (addr_q + AddrW'(1)) : addr_q;

  // Neighbor addresses may wrap at the chain ends; those reads are masked below.
  icms_ram #(
    .Width (1),
    .Depth (NumSpins)
  ) u_spin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign nb_left  = first_q ? 1'b0 : left_q;
  assign nb_right = last_q  ? 1'b0 : ram_rdata;

  always_comb begin
    priority if (first_q) begin
      sel = nb_right ? icms_pkg::REG_NSUM_PH : icms_pkg::REG_NSUM_MH;
    end else if (last_q) begin
      sel = nb_left ? icms_pkg::REG_NSUM_PH : icms_pkg::REG_NSUM_MH;
    end else begin
      unique case ({nb_left, nb_right})
        2'b00:   sel = icms_pkg::REG_NSUM_M1;
        2'b11:   sel = icms_pkg::REG_NSUM_P1;
        default: sel = icms_pkg::REG_NSUM_Z;
      endcase
    end
  end

  assign thr_reg = regs_q[sel];
  assign thr     = centre_q ? thr_reg[icms_pkg::RegW-1:icms_pkg::ThrW]
                            : thr_reg[icms_pkg::ThrW-1:0];

  assign flip     = (op_q == icms_pkg::OP_TRIAL) && range_q && ({1'b0, draw_q} < thr);
  assign new_spin = (op_q == icms_pkg::OP_LOAD) ? val_q : (centre_q ^ flip);
  assign change   = range_q && (new_spin != centre_q);

  always_comb begin
    count_d = count_q;
    if (change) begin
      count_d = new_spin ? (count_q + icms_pkg::CntW'(1)) : (count_q - icms_pkg::CntW'(1));
    end
  end

  assign ram_we = cmd_i.clear_wr || (cmd_i.commit && change);
  assign waddr  = cmd_i.clear_wr ? clr_q : addr_q;
  assign wdata  = cmd_i.clear_wr ? 1'b0 : new_spin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_acc_q   <= flip;
      out_spin_q  <= range_q ? new_spin : 1'b0;
      out_count_q <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_accepted_o = out_acc_q;
  assign out_spin_o     = out_spin_q;
  assign out_count_o    = out_count_q;

  assign sts_o.slot_free  = !out_valid_q || out_ready_i;
  assign sts_o.clear_last = (clr_q == AddrW'(LastIdx));

endmodule

// ===== rtl/ising_chain_metropolis_step_top.sv =====
// Top level of the open-chain Ising Metropolis step block.
//
//  Channel  | Direction | tdata (low bit up)                          | tuser
//  s_axis   | in        | spin_index[5:0] spin_value random_draw[15:0] | operation
//  m_axis   | out       | accepted spin_after up_count[6:0]            | -
//  cfg      | in        | write enable, register index, 34-bit data    | -
//
// A request runs ST_RD_C, ST_RD_L, ST_RD_R, ST_EVAL before the next acceptance:
// the spin RAM has one read port, so the centre and both neighbors are read in turn.
// The result register lets a new request in while the last result waits.
// After reset the RAM is cleared one spin per cycle, all NumSpins spins, with
// s_axis_tready low. A stalled result holds the block in its final step.
module ising_chain_metropolis_step_top #(
  parameter int unsigned NumSpins = icms_pkg::NumSpinsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [icms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [icms_pkg::RegW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // spin_index [5:0], spin_value [6], random_draw [22:7], zero [23]
  input  logic [icms_pkg::InDataW-1:0]  s_axis_tdata,
  // operation [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // accepted [0], spin_after [1], up_count [8:2], zero [15:9]
  output logic [icms_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned PadW = icms_pkg::OutDataW - icms_pkg::CntW - 2;

  icms_pkg::icms_cmd_t       cmd;
  icms_pkg::icms_sts_t       sts;
  logic                      out_acc, out_spin;
  logic [icms_pkg::CntW-1:0] out_count;

  icms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  icms_dp #(
    .NumSpins (NumSpins)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_op_i        (s_axis_tuser),
    .in_idx_i       (s_axis_tdata[5:0]),
    .in_val_i       (s_axis_tdata[6]),
    .in_draw_i      (s_axis_tdata[22:7]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_accepted_o (out_acc),
    .out_spin_o     (out_spin),
    .out_count_o    (out_count),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  assign m_axis_tdata = {PadW'(0), out_count, out_spin, out_acc};

endmodule

// ===== rtl/icms_checker.sv =====
// Port-level checker of the spin chain block and its bind to the top level.
`include "ising_chain_metropolis_step_top_assert.svh"

module icms_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [icms_pkg::OutDataW-1:0] m_axis_tdata
);

  `ICMS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `ICMS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while the previous one is in work")
  `ICMS_ASSERT_NOW(a_up_count_nonzero, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[8:2] != 7'd0, "spin up reported with zero up count")
  `ICMS_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:9] == 7'd0, "result padding not zero")

endmodule

bind ising_chain_metropolis_step_top icms_checker u_icms_checker (.*);
